/* design/cdes_pkg.sv */
// Package with the constants, month tables and helpers of the date to epoch converter.
`timescale 1ns / 1ps

package cdes_pkg;

  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned ZONE_LIMIT   = 1200;
  localparam int unsigned DAYS_YEAR    = 365;
  localparam int unsigned HOURS_DAY    = 24;
  localparam int unsigned MIN_HOUR     = 60;
  localparam int unsigned MAX_DAY      = 31;
  localparam int unsigned MAX_HOUR     = 24;
  localparam int unsigned MAX_MIN      = 60;
  // Leap days counted for the years before the epoch: (EPOCH_YEAR - 1) / 4
  localparam int unsigned EPOCH_QUART  = (EPOCH_YEAR - 1) / 4;
  // Reciprocal of 100 for values below 2^14: q = (v * RECIP_100) >> RECIP_SHIFT
  localparam int unsigned RECIP_100    = 5243;
  localparam int unsigned RECIP_SHIFT  = 19;
  localparam int unsigned NUM_MONTHS   = 12;
  localparam int unsigned OUT_W        = 38;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef logic [3:0] month_idx_t;

  localparam logic [23:0] MONTH_KEY [NUM_MONTHS] = '{
    24'h6A616E, 24'h666562, 24'h6D6172, 24'h617072, 24'h6D6179, 24'h6A756E,
    24'h6A756C, 24'h617567, 24'h736570, 24'h6F6374, 24'h6E6F76, 24'h646563
  };

  // Fold an upper-case ASCII letter to lower case, pass any other byte
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b | 8'h20;
    end
    return b;
  endfunction

  // Days before the first of a month in a common year
  function automatic logic [8:0] days_before(input month_idx_t m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* design/calendar_date_to_epoch_seconds.sv */
// Top level: six-stage pipeline converting a decoded calendar date to epoch seconds.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one decoded date per
//   transaction: month name letters, day, hour, minute, second, year and a
//   signed +HHMM zone number. Output channel (out_valid / out_ready) carries
//   one epoch_seconds value per input transaction, in input order.
//   Throughput is one date per cycle while out_ready stays high; the depth
//   is set by the chain year reciprocal, leap test, day sum, then the hour,
//   minute and second scalings, each in its own register stage.
//   Each stage loads when it is empty or when the stage after it moves, so
//   bubbles close up while the receiver stalls and in_ready stays high until
//   all six stages hold data. Nothing is lost or repeated under stall.
//   Synchronous reset (rst) clears all stage valid bits; the pipeline comes
//   out of reset empty and ready.
`timescale 1ns / 1ps

module calendar_date_to_epoch_seconds (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [23:0]              month_name,
  input  logic [6:0]               day_number,
  input  logic [6:0]               hour_number,
  input  logic [6:0]               minute_number,
  input  logic [6:0]               second_number,
  input  logic [13:0]              year_number,
  input  logic signed [14:0]       zone_number,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [cdes_pkg::OUT_W-1:0] epoch_seconds
);

  import cdes_pkg::*;

  localparam int NSTAGE = 6;

  // Stage valid bits and load enables
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // Stage 1 registers
  month_idx_t   s1_mon;
  logic [4:0]   s1_day;
  logic [4:0]   s1_hour;
  logic [5:0]   s1_min;
  logic [5:0]   s1_sec;
  logic [13:0]  s1_year;
  logic [7:0]   s1_q100;
  logic signed [11:0] s1_zone;

  // Stage 2 registers
  logic [4:0]   s2_day;
  logic [4:0]   s2_hour;
  logic [5:0]   s2_min;
  logic [5:0]   s2_sec;
  logic [22:0]  s2_yoff365;
  logic [11:0]  s2_quart;
  logic [8:0]   s2_dbm;
  logic         s2_zsign;
  logic [10:0]  s2_zabs;
  logic [3:0]   s2_zq;

  // Stage 3 registers
  logic [22:0]  s3_days;
  logic [4:0]   s3_hour;
  logic [5:0]   s3_min;
  logic [5:0]   s3_sec;
  logic signed [4:0] s3_zh;
  logic signed [7:0] s3_zm;

  // Stage 4 registers
  logic signed [28:0] s4_hours;
  logic [5:0]   s4_min;
  logic [5:0]   s4_sec;
  logic signed [7:0] s4_zm;

  // Stage 5 registers
  logic signed [34:0] s5_mins;
  logic [5:0]   s5_sec;

  // Stage 6 register
  logic [OUT_W-1:0] s6_total;

  // Next values
  month_idx_t   mon_next;
  logic [4:0]   day_next;
  logic [4:0]   hour_next;
  logic [5:0]   min_next;
  logic [5:0]   sec_next;
  logic [13:0]  year_next;
  logic [26:0]  yprod;
  logic [23:0]  key;
  logic signed [15:0] zneg;
  logic signed [11:0] zone_next;

  logic [14:0]  hund;
  logic         leap;
  logic [13:0]  yoff;
  logic [11:0]  yquart;
  logic [10:0]  zabs_next;
  logic [23:0]  zprod;

  logic [10:0]  zr;
  logic signed [4:0] zh_next;
  logic signed [7:0] zm_next;
  logic [22:0]  days_next;

  logic signed [28:0] hours_next;
  logic signed [34:0] mins_next;
  logic signed [40:0] total_wide;
  logic [OUT_W-1:0]   total_next;

  // Advance a stage when it is empty or its successor takes its data
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = vld[NSTAGE-1];
  assign epoch_seconds = s6_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: match month, clamp fields, negate zone, reciprocal of year / 100
  always_comb begin
    key = {fold_byte(month_name[23:16]), fold_byte(month_name[15:8]),
           fold_byte(month_name[7:0])};
    mon_next = '0;
    for (int m = NUM_MONTHS - 1; m >= 0; m--) begin
      if (MONTH_KEY[m] == key) begin
        mon_next = month_idx_t'(m);
      end
    end
    year_next = (year_number < 14'(EPOCH_YEAR)) ? 14'(EPOCH_YEAR) : year_number;
    day_next  = (day_number == 7'd0 || day_number > 7'(MAX_DAY)) ? 5'd1 : day_number[4:0];
    hour_next = (hour_number > 7'(MAX_HOUR)) ? 5'd0 : hour_number[4:0];
    min_next  = (minute_number > 7'(MAX_MIN)) ? 6'd0 : minute_number[5:0];
    sec_next  = (second_number > 7'(MAX_MIN)) ? 6'd0 : second_number[5:0];
    yprod     = 27'(year_next) * 27'(RECIP_100);
    zneg      = -16'(zone_number);
    if (zneg > $signed(16'(ZONE_LIMIT)) || zneg < -$signed(16'(ZONE_LIMIT))) begin
      zone_next = '0;
    end else begin
      zone_next = zneg[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mon  <= mon_next;
      s1_day  <= day_next;
      s1_hour <= hour_next;
      s1_min  <= min_next;
      s1_sec  <= sec_next;
      s1_year <= year_next;
      s1_q100 <= yprod[RECIP_SHIFT+7:RECIP_SHIFT];
      s1_zone <= zone_next;
    end
  end

  // Stage 2: leap test, year days, days before month, zone hours
  always_comb begin
    hund   = 15'(s1_q100) * 15'd100;
    leap   = (s1_year[1:0] == 2'd0) && ((hund[13:0] != s1_year) || (s1_q100[1:0] == 2'd0));
    yoff   = s1_year - 14'(EPOCH_YEAR);
    yquart = 12'((s1_year - 14'd1) >> 2) - 12'(EPOCH_QUART);
    zabs_next = (s1_zone < 0) ? 11'(-s1_zone) : 11'(s1_zone);
    zprod  = 24'(zabs_next) * 24'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_day     <= s1_day;
      s2_hour    <= s1_hour;
      s2_min     <= s1_min;
      s2_sec     <= s1_sec;
      s2_yoff365 <= 23'(yoff) * 23'(DAYS_YEAR);
      s2_quart   <= yquart;
      s2_dbm     <= days_before(s1_mon) + 9'((leap && s1_mon >= month_idx_t'(2)) ? 1 : 0);
      s2_zsign   <= s1_zone < 0;
      s2_zabs    <= zabs_next;
      s2_zq      <= zprod[RECIP_SHIFT+3:RECIP_SHIFT];
    end
  end

  // Stage 3: sum days, split zone into signed hour and minute parts
  always_comb begin
    zr        = s2_zabs - 11'(s2_zq) * 11'd100;
    zh_next   = s2_zsign ? -$signed({1'b0, s2_zq}) : $signed({1'b0, s2_zq});
    zm_next   = s2_zsign ? -$signed({1'b0, zr[6:0]}) : $signed({1'b0, zr[6:0]});
    days_next = s2_yoff365 + 23'(s2_quart) + 23'(s2_dbm) + 23'(s2_day) - 23'd1;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_days <= days_next;
      s3_hour <= s2_hour;
      s3_min  <= s2_min;
      s3_sec  <= s2_sec;
      s3_zh   <= zh_next;
      s3_zm   <= zm_next;
    end
  end

  // Stage 4: scale days to hours, add the hour and the zone hours
  assign hours_next = $signed(29'(s3_days)) * 29'sd24 + $signed(29'(s3_hour)) + 29'(s3_zh);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_hours <= hours_next;
      s4_min   <= s3_min;
      s4_sec   <= s3_sec;
      s4_zm    <= s3_zm;
    end
  end

  // Stage 5: scale hours to minutes, add the minute and the zone minutes
  assign mins_next = 35'(s4_hours) * 35'sd60 + $signed(35'(s4_min)) + 35'(s4_zm);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_mins <= mins_next;
      s5_sec  <= s4_sec;
    end
  end

  // Stage 6: scale minutes to seconds, add the second, clamp to the output range
  always_comb begin
    total_wide = 41'(s5_mins) * 41'sd60 + $signed(41'(s5_sec));
    if (total_wide < 0) begin
      total_next = '0;
    end else if (total_wide > $signed(41'(OUT_MAX))) begin
      total_next = OUT_MAX;
    end else begin
      total_next = total_wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_total <= total_next;
    end
  end

endmodule
